/* design/msic_pkg.sv */
`timescale 1ns / 1ps
package msic_pkg;
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_VERTEX   = 2'd1;
  localparam logic [1:0] KIND_FRAME    = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_POLY_MODE  = 2'd2;

  localparam logic [31:0] RANGE_HIGH_RESET = 32'h7fff_ffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] load_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic signed [31:0] point_value;
    logic [11:0] vertex_ref;
    logic        end_of_polygon;
    logic signed [31:0] polygon_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] compact_index;
    logic        new_point;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic signed [31:0] out_value;
    logic        first_of_polygon;
    logic [15:0] polygon_offset;
    logic signed [31:0] out_polygon_value;
    logic        truncated;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // capture input item, do load / vertex / frame work
    logic clr_start;  // start remap clearing sweep
    logic clr_step;   // clear one remap valid entry
    logic emit_wr;    // form result, update remap, advance
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic poly_ready;  // end of polygon seen and kept
    logic emit_last;   // current emit vertex is the final one
  } dp_stat_t;
endpackage

/* design/msic_if.sv */
`timescale 1ns / 1ps
interface msic_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/msic_datapath.sv */
`timescale 1ns / 1ps
module msic_datapath import msic_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_POLY_VERTS = 16,
  parameter int MAX_VERTS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  in_item_t    in_item,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  input  logic        per_polygon_mode,
  output out_item_t   res
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int BW = $clog2(MAX_POLY_VERTS);
  localparam int CW = $clog2(MAX_POLY_VERTS + 1);
  localparam logic [15:0] VLIM = (MAX_VERTS - 1 < 65535) ? 16'(MAX_VERTS - 1) : 16'hffff;

  logic [63:0] coord_store [MAX_POINTS];
  logic [31:0] zcoord_store [MAX_POINTS];
  logic [31:0] value_store [MAX_POINTS];
  logic        remap_valid [MAX_POINTS];
  logic [11:0] remap_table [MAX_POINTS];
  logic [PW-1:0] polygon_buffer [MAX_POLY_VERTS];

  logic [CW-1:0] buffered_count;
  logic          any_in_range;
  logic          dropped;
  logic [12:0]   emitted_points;
  logic [15:0]   emitted_vertices;
  logic [15:0]   start_offset;
  logic          keep_pending;
  logic [31:0]   poly_value;
  logic [CW-1:0] emit_k;
  logic [PW-1:0] clr_addr;
  logic          clr_done;
  logic          chk_pending;

  // registered reads
  logic [63:0]   rd_coord;
  logic [31:0]   rd_z;
  logic [31:0]   rd_val;
  logic          rd_valid;
  logic [11:0]   rd_map;
  logic [PW-1:0] rd_p;
  logic [31:0]   chk_val;

  logic [PW-1:0] ld_slot;
  logic [PW-1:0] v_slot;
  logic [PW-1:0] emit_p;

  function automatic logic in_iv(input logic [31:0] v, input logic [31:0] lo,
                                 input logic [31:0] hi);
    in_iv = ($signed(v) >= $signed(lo)) && ($signed(v) <= $signed(hi));
  endfunction

  assign ld_slot = in_item.load_index[PW-1:0];
  assign v_slot  = in_item.vertex_ref[PW-1:0];
  assign emit_p  = polygon_buffer[emit_k[BW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.take && in_item.kind == KIND_LOAD) begin
      coord_store[ld_slot]  <= {in_item.point_x, in_item.point_y};
      zcoord_store[ld_slot] <= in_item.point_z;
      value_store[ld_slot]  <= in_item.point_value;
    end
    chk_val <= value_store[v_slot];
    rd_coord <= coord_store[emit_p];
    rd_z     <= zcoord_store[emit_p];
    rd_val   <= value_store[emit_p];
    rd_map   <= remap_table[emit_p];
    rd_p     <= emit_p;
    if (cmd.emit_wr && !rd_valid) remap_table[rd_p] <= emitted_points[11:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) remap_valid[clr_addr] <= 1'b0;
    else if (cmd.emit_wr) remap_valid[rd_p] <= 1'b1;
    rd_valid <= remap_valid[emit_p];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_item.kind == KIND_VERTEX && buffered_count < CW'(MAX_POLY_VERTS))
      polygon_buffer[buffered_count[BW-1:0]] <= v_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffered_count <= '0;
      any_in_range <= 1'b0;
      dropped <= 1'b0;
      emitted_points <= '0;
      emitted_vertices <= '0;
      keep_pending <= 1'b0;
      emit_k <= '0;
      clr_addr <= '0;
      // remap valid table is swept clean after reset
      clr_done <= 1'b0;
      chk_pending <= 1'b0;
    end else begin
      keep_pending <= 1'b0;
      chk_pending <= 1'b0;
      if (cmd.clr_start) begin
        clr_addr <= '0;
        clr_done <= 1'b0;
        emitted_points <= '0;
        emitted_vertices <= '0;
        buffered_count <= '0;
        any_in_range <= 1'b0;
        dropped <= 1'b0;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == PW'(MAX_POINTS - 1)) clr_done <= 1'b1;
      end
      if (cmd.take && in_item.kind == KIND_VERTEX) begin
        if (buffered_count < CW'(MAX_POLY_VERTS)) begin
          buffered_count <= buffered_count + 1'b1;
          chk_pending <= 1'b1;
        end else begin
          dropped <= 1'b1;
        end
        poly_value <= in_item.polygon_value;
        keep_pending <= in_item.end_of_polygon;
      end
      // after a vertex capture: its stored scalar is now registered in chk_val
      if (keep_pending) begin
        if ((per_polygon_mode ? in_iv(poly_value, range_low, range_high)
             : (any_in_range || (chk_pending && in_iv(chk_val, range_low, range_high))))
            && buffered_count != '0) begin
          emit_k <= '0;
          start_offset <= emitted_vertices;
        end else begin
          buffered_count <= '0;
          any_in_range <= 1'b0;
          dropped <= 1'b0;
        end
      end else if (chk_pending && in_iv(chk_val, range_low, range_high)) begin
        any_in_range <= 1'b1;
      end
      if (cmd.emit_wr) begin
        if (!rd_valid && emitted_points < 13'h1fff) emitted_points <= emitted_points + 1'b1;
        if (emitted_vertices < VLIM) emitted_vertices <= emitted_vertices + 1'b1;
        emit_k <= emit_k + 1'b1;
        if (stat.emit_last) begin
          buffered_count <= '0;
          any_in_range <= 1'b0;
          dropped <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    stat.clr_done   = clr_done;
    stat.poly_ready = keep_pending &&
      (per_polygon_mode ? in_iv(poly_value, range_low, range_high)
       : (any_in_range || (chk_pending && in_iv(chk_val, range_low, range_high))))
      && buffered_count != '0;
    stat.emit_last  = (emit_k + 1'b1) == buffered_count;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wr) begin
      res.compact_index <= rd_valid ? rd_map : emitted_points[11:0];
      res.new_point <= !rd_valid;
      res.out_x <= rd_valid ? 32'd0 : rd_coord[63:32];
      res.out_y <= rd_valid ? 32'd0 : rd_coord[31:0];
      res.out_z <= rd_valid ? 32'd0 : rd_z;
      res.out_value <= (rd_valid || per_polygon_mode) ? 32'd0 : rd_val;
      res.first_of_polygon <= emit_k == '0;
      res.polygon_offset <= start_offset;
      res.out_polygon_value <= (emit_k == '0 && per_polygon_mode) ? poly_value : 32'd0;
      res.truncated <= dropped;
      res.last <= stat.emit_last;
    end
  end
endmodule

/* design/msic_ctrl.sv */
`timescale 1ns / 1ps
module msic_ctrl import msic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] in_kind,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       wrote_last;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_kind == KIND_FRAME) begin
            cmd.clr_start = 1'b1;
            state_next = S_CLEAR;
          end else if (in_kind == KIND_VERTEX) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: state_next = stat.poly_ready ? S_RD : S_IDLE;
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          cmd.clr_step = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        if (!out_valid || out_ready) begin
          cmd.emit_wr = 1'b1;
          out_valid_next = 1'b1;
          state_next = stat.emit_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // sweep the remap table before the first item
      state <= S_CLEAR;
      out_valid <= 1'b0;
      wrote_last <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      wrote_last <= cmd.emit_wr && stat.emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == S_IDLE) else $error("take outside idle");
  a_emit_space: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_wr |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    wrote_last |-> state == S_IDLE) else $error("emit did not end");
`endif
endmodule

/* design/mesh_scalar_interval_clip.sv */
`timescale 1ns / 1ps
// Compacts a polygon mesh to the polygons whose scalar (the polygon value in
// per-polygon mode, else that of any vertex's point) lies in the inclusive
// interval [range_low, range_high]: load items fill the point store, vertex
// items are buffered up to MAX_POLY_VERTS per polygon, and a kept polygon
// emits one result per vertex with a compact point index, coordinates on the
// first use of a point, and a frame item restarts the numbering. Items are
// handled one at a time. After reset and after each frame item the remap
// valid table is swept one entry a cycle and input is held off. A vertex item
// is captured, then its scalar is checked. A kept polygon then emits each
// vertex by a store read, then a remap update and result register, and stalls
// while the output holds a result that is not yet taken.
module mesh_scalar_interval_clip import msic_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_POLY_VERTS = 16,
  parameter int MAX_VERTS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  msic_if.sink        in_ch,
  msic_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] range_low, range_high;
  logic        per_polygon_mode;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  in_item_t    in_item;
  out_item_t   res;

  assign pready = 1'b1;
  assign in_item = in_ch.payload;
  assign out_ch.payload = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= '0;
      range_high <= RANGE_HIGH_RESET;
      per_polygon_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RANGE_LOW: range_low <= pwdata;
        REG_RANGE_HIGH: range_high <= pwdata;
        REG_POLY_MODE: per_polygon_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_LOW: prdata = range_low;
      REG_RANGE_HIGH: prdata = range_high;
      REG_POLY_MODE: prdata = {31'd0, per_polygon_mode};
      default: prdata = '0;
    endcase
  end

  msic_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_kind(in_item.kind), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  msic_datapath #(
    .MAX_POINTS(MAX_POINTS), .MAX_POLY_VERTS(MAX_POLY_VERTS), .MAX_VERTS(MAX_VERTS)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .in_item,
    .range_low, .range_high, .per_polygon_mode, .res
  );
endmodule
